@@ rtl/cbfa_pkg.sv @@
// shared types, constants and helpers of the cubic b-spline feature accumulator
`timescale 1ns / 1ps

package cbfa_pkg;

   localparam int INTERACTIONS = 4;
   localparam int MAX_KNOTS    = 32;
   localparam int MAX_ELEMENTS = 8;

   localparam int COEFS     = 16;
   localparam int TERMS     = 4;
   localparam int MIN_KNOTS = 8;

   localparam int IX_W       = (INTERACTIONS > 1) ? $clog2(INTERACTIONS) : 1;
   localparam int ELEM_W     = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
   localparam int KNOT_IW    = $clog2(MAX_KNOTS);
   localparam int CNT_W      = $clog2(MAX_KNOTS + 1);
   localparam int KNOT_DEPTH = INTERACTIONS * MAX_KNOTS;
   localparam int KNOT_AW    = $clog2(KNOT_DEPTH);
   localparam int COEF_DEPTH = KNOT_DEPTH * COEFS;
   localparam int COEF_AW    = $clog2(COEF_DEPTH);

   localparam logic signed [63:0] SAT_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] SAT_MIN = 64'sh8000_0000_0000_0000;
   localparam logic signed [63:0] ONE_Q40 = 64'sh0000_0100_0000_0000;

   typedef enum logic [2:0] {
      CMD_SET_COUNT  = 3'd0,
      CMD_LOAD_KNOT  = 3'd1,
      CMD_LOAD_COEF  = 3'd2,
      CMD_COUNT_ELEM = 3'd3,
      CMD_DISTANCE   = 3'd4,
      CMD_READ       = 3'd5
   } cmd_type;

   typedef struct packed {
      logic [2:0]         command;
      logic [1:0]         interaction;
      logic [8:0]         slot;
      logic signed [63:0] value;
   } req_type;

   typedef struct packed {
      logic [8:0]         feature_address;
      logic signed [63:0] feature_value;
   } rsp_type;

   function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
      logic signed [63:0] s;
      s = a + b;
      if ((a[63] == b[63]) && (s[63] != a[63])) begin
         return a[63] ? SAT_MIN : SAT_MAX;
      end
      return s;
   endfunction

   function automatic logic [31:0] sat_u32(input logic signed [63:0] v);
      if (v[63]) begin
         return 32'd0;
      end else if (|v[62:32]) begin
         return 32'hFFFF_FFFF;
      end
      return v[31:0];
   endfunction

endpackage

@@ rtl/cbfa_ram.sv @@
// generic single-port-write, single-port-read ram with registered read
`timescale 1ns / 1ps

module cbfa_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/cbfa_mul.sv @@
// 64x64 unsigned multiplier built from four registered 32x32 partial products
`timescale 1ns / 1ps

module cbfa_mul (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [63:0]  a,
   input  logic [63:0]  b,
   output logic [127:0] prod,
   output logic         done
);

   logic         busy_ff;
   logic         done_ff;
   logic [2:0]   cnt_ff;
   logic [63:0]  a_ff;
   logic [63:0]  b_ff;
   logic [63:0]  pp_ff;
   logic [1:0]   sh_ff;
   logic [127:0] acc_ff;
   logic [31:0]  a_half;
   logic [31:0]  b_half;
   logic [127:0] pp_shifted;

   // partial product cnt uses a half cnt[0] and b half cnt[1]
   always_comb begin
      a_half = cnt_ff[0] ? a_ff[63:32] : a_ff[31:0];
      b_half = cnt_ff[1] ? b_ff[63:32] : b_ff[31:0];
      case (sh_ff)
         2'd0:    pp_shifted = {64'd0, pp_ff};
         2'd1:    pp_shifted = {32'd0, pp_ff, 32'd0};
         default: pp_shifted = {pp_ff, 64'd0};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 3'd0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 3'd0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 3'd1;
            if (cnt_ff == 3'd4) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff   <= a;
         b_ff   <= b;
         acc_ff <= '0;
      end else if (busy_ff) begin
         if (cnt_ff != 3'd4) begin
            pp_ff <= a_half * b_half;
            sh_ff <= 2'(cnt_ff[0]) + 2'(cnt_ff[1]);
         end
         if (cnt_ff != 3'd0) begin
            acc_ff <= acc_ff + pp_shifted;
         end
      end
   end

   assign prod = acc_ff;
   assign done = done_ff;

endmodule

@@ rtl/cubic_bspline_feature_accumulator.sv @@
// top level of the cubic b-spline feature accumulator
`timescale 1ns / 1ps

// Command-driven feature accumulator. Items carry a command: set knot count, load knot,
// load coefficient, count element, distance, read and clear. One item is worked at a
// time; req_stall is high while an item is in progress. Knots (128 x 32), coefficients
// (2048 x 64) and basis accumulators (128 x 64) live in synchronous rams; accumulators
// carry per-entry valid bits cleared by reset, so no clearing pass is needed.
// Knot count and knot/coefficient loads finish in the idle state; element counts take a
// separate update state, and a read and clear may wait for the result register. A distance
// scans the knots downward for its interval, forms the r^2 and r^3 products, and for each
// touched basis does four coefficient reads, three 64x64 products on the shared four-pass
// 32x32 multiplier and an accumulator read-modify-write.
// A finished result waits in an output register, and the next item is accepted meanwhile.

module cubic_bspline_feature_accumulator (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  cbfa_pkg::req_type req_item,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output cbfa_pkg::rsp_type rsp_item
);
   import cbfa_pkg::*;

   typedef enum logic [13:0] {
      S_IDLE = 14'b00000000000001,
      S_ELEM = 14'b00000000000010,
      S_KRD  = 14'b00000000000100,
      S_KCHK = 14'b00000000001000,
      S_MUL  = 14'b00000000010000,
      S_RND  = 14'b00000000100000,
      S_CRD  = 14'b00000001000000,
      S_CDAT = 14'b00000010000000,
      S_SUM  = 14'b00000100000000,
      S_ARD  = 14'b00001000000000,
      S_AWR  = 14'b00010000000000,
      S_RRD  = 14'b00100000000000,
      S_RDAT = 14'b01000000000000,
      S_ROUT = 14'b10000000000000
   } state_type;

   // what the shared multiplier is working on
   typedef enum logic [1:0] {
      J_R2   = 2'd0,
      J_R3   = 2'd1,
      J_TERM = 2'd2
   } job_type;

   state_type          state_ff, state_in;
   job_type            job_ff, job_in;
   req_type            item_ff, item_in;
   logic [31:0]        r_ff, r_in;
   logic [63:0]        r2_ff, r2_in;
   logic [63:0]        r3_ff, r3_in;
   logic [KNOT_IW-1:0] pos_ff, pos_in;
   logic               first_ff, first_in;
   logic [1:0]         j_ff, j_in;
   logic [1:0]         k_ff, k_in;
   logic               neg_ff, neg_in;
   logic signed [63:0] term_ff, term_in;
   logic signed [63:0] sum_ff, sum_in;
   logic signed [63:0] word_ff, word_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;
   logic               accv_ff;

   logic [CNT_W-1:0]   count_ff [INTERACTIONS];
   logic signed [63:0] elem_ff [MAX_ELEMENTS];
   logic               acc_valid_ff [KNOT_DEPTH];

   // memory ports
   logic               knot_we, coef_we, acc_we;
   logic [KNOT_AW-1:0] knot_wr_addr, knot_rd_addr;
   logic [31:0]        knot_rd_data;
   logic [COEF_AW-1:0] coef_wr_addr, coef_rd_addr;
   logic [63:0]        coef_rd_data;
   logic [KNOT_AW-1:0] acc_addr_dist, acc_addr_read, acc_wr_addr, acc_rd_addr;
   logic [63:0]        acc_wdata, acc_rd_data;

   // multiplier
   logic               mul_start, mul_done;
   logic [63:0]        mul_a, mul_b;
   logic [127:0]       mul_prod;

   logic               req_ix_ok;
   logic [CNT_W-1:0]   req_count;
   logic [CNT_W-1:0]   count_wdata;
   logic               cnt_we;
   logic               elem_we;
   logic signed [63:0] elem_wdata, elem_rd;
   logic               slot_is_elem, slot_is_acc;
   logic [KNOT_IW-1:0] basis;
   logic [64:0]        rs_r3, rs_term;
   logic [63:0]        coef_mag;
   logic signed [63:0] term_sat;
   logic signed [63:0] acc_old;

   // round half up after a right shift by s, with overflow flag above 64 bits
   function automatic logic [64:0] round_shift(input logic [127:0] p, input int s);
      logic [127:0] t;
      logic [127:0] q;
      t = p + (128'd1 << (s - 1));
      q = t >> s;
      return {|(t >> (s + 64)), q[63:0]};
   endfunction

   assign req_ix_ok = 32'(req_item.interaction) < INTERACTIONS;
   assign req_count = count_ff[IX_W'(req_item.interaction)];
   assign slot_is_elem = 32'(item_ff.slot) < MAX_ELEMENTS;
   assign slot_is_acc  = !slot_is_elem && ((32'(item_ff.slot) - MAX_ELEMENTS) < KNOT_DEPTH);
   assign elem_rd      = elem_ff[ELEM_W'(item_ff.slot)];
   assign basis        = pos_ff - KNOT_IW'(j_ff);

   // knot count saturates into 0 .. max knots
   always_comb begin
      if (req_item.value[63]) begin
         count_wdata = '0;
      end else if (req_item.value > 64'(MAX_KNOTS)) begin
         count_wdata = CNT_W'(MAX_KNOTS);
      end else begin
         count_wdata = req_item.value[CNT_W-1:0];
      end
   end

   // addresses
   assign knot_wr_addr  = KNOT_AW'(32'(req_item.interaction) * MAX_KNOTS + 32'(req_item.slot));
   assign knot_rd_addr  = KNOT_AW'(32'(item_ff.interaction) * MAX_KNOTS + 32'(pos_ff));
   assign coef_wr_addr  = COEF_AW'(32'(req_item.interaction) * MAX_KNOTS * COEFS
                                   + 32'(req_item.slot));
   assign coef_rd_addr  = COEF_AW'((32'(item_ff.interaction) * MAX_KNOTS + 32'(basis)) * COEFS
                                   + 32'(j_ff) * TERMS + 32'(k_ff));
   assign acc_addr_dist = KNOT_AW'(32'(item_ff.interaction) * MAX_KNOTS + 32'(basis));
   assign acc_addr_read = KNOT_AW'(32'(item_ff.slot) - MAX_ELEMENTS);
   assign acc_rd_addr   = (state_ff == S_RRD)  ? acc_addr_read : acc_addr_dist;
   assign acc_wr_addr   = (state_ff == S_RDAT) ? acc_addr_read : acc_addr_dist;

   // rounding of r^3 and of the terms; terms come back to q24.40, saturating on magnitude
   always_comb begin
      rs_r3 = round_shift(mul_prod, 32);
      case (k_ff)
         2'd1:    rs_term = round_shift(mul_prod, 26);
         2'd2:    rs_term = round_shift(mul_prod, 52);
         default: rs_term = round_shift(mul_prod, 46);
      endcase
      if (!neg_ff) begin
         term_sat = (rs_term[64] || rs_term[63]) ? SAT_MAX : rs_term[63:0];
      end else begin
         term_sat = (rs_term[64] || rs_term[63]) ? SAT_MIN : -rs_term[63:0];
      end
      coef_mag = coef_rd_data[63] ? (64'd0 - coef_rd_data) : coef_rd_data;
      acc_old  = accv_ff ? acc_rd_data : 64'sd0;
   end

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      item_in      = item_ff;
      r_in         = r_ff;
      r2_in        = r2_ff;
      r3_in        = r3_ff;
      pos_in       = pos_ff;
      first_in     = first_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      neg_in       = neg_ff;
      term_in      = term_ff;
      sum_in       = sum_ff;
      word_in      = word_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      knot_we      = 1'b0;
      coef_we      = 1'b0;
      acc_we       = 1'b0;
      acc_wdata    = '0;
      cnt_we       = 1'b0;
      elem_we      = 1'b0;
      elem_wdata   = '0;
      mul_start    = 1'b0;
      mul_a        = '0;
      mul_b        = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               item_in = req_item;
               case (req_item.command)
                  CMD_SET_COUNT: cnt_we = req_ix_ok;
                  CMD_LOAD_KNOT: knot_we = req_ix_ok && (32'(req_item.slot) < MAX_KNOTS);
                  CMD_LOAD_COEF: coef_we = req_ix_ok
                                           && ((32'(req_item.slot) / COEFS) < MAX_KNOTS);
                  CMD_COUNT_ELEM: state_in = S_ELEM;
                  CMD_DISTANCE: begin
                     if (req_ix_ok && (32'(req_count) >= MIN_KNOTS)) begin
                        r_in     = sat_u32(req_item.value);
                        pos_in   = KNOT_IW'(req_count - CNT_W'(TERMS));
                        first_in = 1'b1;
                        state_in = S_KRD;
                     end
                  end
                  CMD_READ: state_in = S_RRD;
                  default: ;
               endcase
            end
         end
         S_ELEM: begin
            elem_we    = slot_is_elem;
            elem_wdata = sat_add(elem_rd, ONE_Q40);
            state_in   = S_IDLE;
         end
         S_KRD: state_in = S_KCHK;
         S_KCHK: begin
            first_in = 1'b0;
            if (first_ff && (r_ff > knot_rd_data)) begin
               // outside the support
               state_in = S_IDLE;
            end else if ((pos_ff > KNOT_IW'(3)) && (r_ff <= knot_rd_data)) begin
               pos_in   = pos_ff - KNOT_IW'(1);
               state_in = S_KRD;
            end else begin
               mul_start = 1'b1;
               mul_a     = {32'd0, r_ff};
               mul_b     = {32'd0, r_ff};
               job_in    = J_R2;
               state_in  = S_MUL;
            end
         end
         S_MUL: begin
            if (mul_done) begin
               state_in = S_RND;
            end
         end
         S_RND: begin
            case (job_ff)
               J_R2: begin
                  r2_in     = mul_prod[63:0];
                  mul_start = 1'b1;
                  mul_a     = mul_prod[63:0];
                  mul_b     = {32'd0, r_ff};
                  job_in    = J_R3;
                  state_in  = S_MUL;
               end
               J_R3: begin
                  r3_in    = rs_r3[63:0];
                  j_in     = 2'd0;
                  k_in     = 2'd0;
                  state_in = S_CRD;
               end
               default: begin
                  term_in  = term_sat;
                  state_in = S_SUM;
               end
            endcase
         end
         S_CRD: state_in = S_CDAT;
         S_CDAT: begin
            if (k_ff == 2'd0) begin
               sum_in   = coef_rd_data;
               k_in     = 2'd1;
               state_in = S_CRD;
            end else begin
               neg_in    = coef_rd_data[63];
               mul_start = 1'b1;
               mul_a     = coef_mag;
               case (k_ff)
                  2'd1:    mul_b = {32'd0, r_ff};
                  2'd2:    mul_b = r2_ff;
                  default: mul_b = r3_ff;
               endcase
               job_in   = J_TERM;
               state_in = S_MUL;
            end
         end
         S_SUM: begin
            sum_in = sat_add(sum_ff, term_ff);
            if (k_ff == 2'd3) begin
               state_in = S_ARD;
            end else begin
               k_in     = k_ff + 2'd1;
               state_in = S_CRD;
            end
         end
         S_ARD: state_in = S_AWR;
         S_AWR: begin
            acc_we    = 1'b1;
            acc_wdata = sat_add(acc_old, sum_ff);
            if (j_ff == 2'd3) begin
               state_in = S_IDLE;
            end else begin
               j_in     = j_ff + 2'd1;
               k_in     = 2'd0;
               state_in = S_CRD;
            end
         end
         S_RRD: state_in = S_RDAT;
         S_RDAT: begin
            // read and clear
            if (slot_is_elem) begin
               word_in = elem_rd;
               elem_we = 1'b1;
            end else if (slot_is_acc) begin
               word_in = acc_old;
               acc_we  = 1'b1;
            end else begin
               word_in = '0;
            end
            state_in = S_ROUT;
         end
         S_ROUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in           = 1'b1;
               rsp_in.feature_address = item_ff.slot;
               rsp_in.feature_value   = word_ff;
               state_in               = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < INTERACTIONS; i++) begin
            count_ff[i] <= '0;
         end
         for (int i = 0; i < MAX_ELEMENTS; i++) begin
            elem_ff[i] <= '0;
         end
         for (int i = 0; i < KNOT_DEPTH; i++) begin
            acc_valid_ff[i] <= 1'b0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cnt_we) begin
            count_ff[IX_W'(req_item.interaction)] <= count_wdata;
         end
         if (elem_we) begin
            elem_ff[ELEM_W'(item_ff.slot)] <= elem_wdata;
         end
         if (acc_we) begin
            acc_valid_ff[acc_wr_addr] <= 1'b1;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      job_ff   <= job_in;
      item_ff  <= item_in;
      r_ff     <= r_in;
      r2_ff    <= r2_in;
      r3_ff    <= r3_in;
      pos_ff   <= pos_in;
      first_ff <= first_in;
      j_ff     <= j_in;
      k_ff     <= k_in;
      neg_ff   <= neg_in;
      term_ff  <= term_in;
      sum_ff   <= sum_in;
      word_ff  <= word_in;
      rsp_ff   <= rsp_in;
      accv_ff  <= acc_valid_ff[acc_rd_addr];
   end

   cbfa_ram #(.WIDTH(32), .DEPTH(KNOT_DEPTH)) u_knot_ram (
      .clock   (clock),
      .wr_en   (knot_we),
      .wr_addr (knot_wr_addr),
      .wr_data (sat_u32(req_item.value)),
      .rd_addr (knot_rd_addr),
      .rd_data (knot_rd_data)
   );

   cbfa_ram #(.WIDTH(64), .DEPTH(COEF_DEPTH)) u_coef_ram (
      .clock   (clock),
      .wr_en   (coef_we),
      .wr_addr (coef_wr_addr),
      .wr_data (req_item.value),
      .rd_addr (coef_rd_addr),
      .rd_data (coef_rd_data)
   );

   cbfa_ram #(.WIDTH(64), .DEPTH(KNOT_DEPTH)) u_acc_ram (
      .clock   (clock),
      .wr_en   (acc_we),
      .wr_addr (acc_wr_addr),
      .wr_data (acc_wdata),
      .rd_addr (acc_rd_addr),
      .rd_data (acc_rd_data)
   );

   cbfa_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .prod  (mul_prod),
      .done  (mul_done)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // multiplier finishes only while the sequencer waits for it
   a_mul_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (state_ff == S_MUL))
      else $error("multiplier done outside wait state");

   // a new result only comes from the output state
   a_rsp_from_rout: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_ROUT))
      else $error("result raised outside output state");

   // basis index never goes below zero
   a_basis_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CRD) |-> (pos_ff >= KNOT_IW'(3)))
      else $error("interval below three during coefficient read");

   // accumulator is never written while its old value is still in flight
   a_acc_we_state: assert property (@(posedge clock) disable iff (reset)
      acc_we |-> ($past(state_ff == S_ARD) || $past(state_ff == S_RRD)))
      else $error("accumulator write without preceding read");

endmodule
